/* hdl/sequenced_input_fifo_core_macros.svh */
// Assertion macros shared by the sequenced input FIFO RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SEQUENCED_INPUT_FIFO_CORE_MACROS_SVH
`define SEQUENCED_INPUT_FIFO_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk, idle during reset.
`define SIF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sequenced_input_fifo_core: assertion failed");

// Next-cycle implication, sampled on aclk, idle during reset.
`define SIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sequenced_input_fifo_core: assertion failed");

`endif

/* hdl/sif_pkg.sv */
// Shared types and constants of the sequenced input FIFO.
// No dependencies; imported by sif_datapath, sif_ctrl, the top level and the testbench.
package sif_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 64;
    localparam int SEQ_W        = 32;
    localparam int PORT_PAY_W   = 64;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int SUM_W        = CNT_W + 1;
    localparam int ENTRY_W      = SEQ_W + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_STALE    = 3'd1,
        ST_GAP      = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_POPPED   = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // datapath -> top level checks
    typedef struct packed {
        logic [CNT_W-1:0] count;
    } dp_stat_t;

endpackage

/* hdl/sif_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sif_datapath.sv */
// Datapath: captured item, ring pointers, sequence checks, entry RAM, result registers.
// Depends on sif_pkg and sif_ram.
module sif_datapath
    import sif_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output dp_stat_t              stat,
    input  logic                  s_mode,
    input  logic [SEQ_W-1:0]      s_in_sequence,
    input  logic [PORT_PAY_W-1:0] s_in_payload,
    output logic [2:0]            m_status,
    output logic [SEQ_W-1:0]      m_out_sequence,
    output logic [PORT_PAY_W-1:0] m_out_payload
);

    // captured item
    mode_t                   mode_reg;
    logic [SEQ_W-1:0]        seq_in_reg;
    logic [PAYLOAD_BITS-1:0] pay_in_reg;

    // FIFO state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SEQ_W-1:0] last_reg, last_next;
    logic             have_reg, have_next;

    // result
    status_t              status_reg, status_next;
    logic [SEQ_W-1:0]     oseq_reg, oseq_next;
    logic [PAYLOAD_BITS-1:0] opay_reg, opay_next;

    logic [SEQ_W-1:0]   seq_diff;
    logic [SEQ_W-1:0]   expected;
    logic               is_newer;
    logic [SUM_W-1:0]   tail_sum;
    logic [IDX_W-1:0]   tail_idx;
    logic               full;
    logic               wr_en;
    logic [ENTRY_W-1:0] rd_entry;

    sif_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (tail_idx),
        .wdata ({seq_in_reg, pay_in_reg}),
        .raddr (head_reg),
        .rdata (rd_entry)
    );

    always_comb begin
        seq_diff = seq_in_reg - last_reg;
        is_newer = (seq_diff != '0) && !seq_diff[SEQ_W-1];
        expected = last_reg + SEQ_W'(1);
        if (expected == '0) begin
            expected = SEQ_W'(1);
        end
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
        full     = (count_reg == CNT_W'(DEPTH));
    end

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        have_next   = have_reg;
        status_next = status_reg;
        oseq_next   = oseq_reg;
        opay_next   = opay_reg;
        wr_en       = 1'b0;
        if (cmd.commit) begin
            oseq_next = '0;
            opay_next = '0;
            if (mode_reg == MODE_PUSH) begin
                if (seq_in_reg == '0) begin
                    status_next = ST_STALE;
                end else if (have_reg && !is_newer) begin
                    status_next = ST_STALE;
                end else if (have_reg && (seq_in_reg != expected)) begin
                    status_next = ST_GAP;
                end else if (full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    status_next = ST_ACCEPTED;
                    wr_en       = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    last_next   = seq_in_reg;
                    have_next   = 1'b1;
                end
            end else begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    // read data was fetched at the head slot on capture
                    status_next = ST_POPPED;
                    oseq_next   = rd_entry[ENTRY_W-1 -: SEQ_W];
                    opay_next   = rd_entry[PAYLOAD_BITS-1:0];
                    count_next  = count_reg - CNT_W'(1);
                    head_next   = (head_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                  : head_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            have_reg  <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= mode_t'(s_mode);
            seq_in_reg <= s_in_sequence;
            pay_in_reg <= s_in_payload[PAYLOAD_BITS-1:0];
        end
        status_reg <= status_next;
        oseq_reg   <= oseq_next;
        opay_reg   <= opay_next;
    end

    assign stat.count     = count_reg;
    assign m_status       = status_reg;
    assign m_out_sequence = oseq_reg;
    assign m_out_payload  = PORT_PAY_W'(opay_reg);

endmodule

/* hdl/sif_ctrl.sv */
// Controller: two-state sequencer plus result-valid flag of the output register.
// Depends on sif_pkg.
module sif_ctrl
    import sif_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            CS_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* hdl/sequenced_input_fifo_core.sv */
// Top level of the sequenced input FIFO: controller, datapath and checks.
// Depends on sif_pkg, sif_ctrl, sif_datapath and sequenced_input_fifo_core_macros.svh.
//
//  Port group   Dir   Handshake          Carries
//  s_*          in    s_valid/s_ready    mode, in_sequence, in_payload
//  m_*          out   m_valid/m_ready    status, out_sequence, out_payload
//
// An item passes through two steps: a transfer on s_*, then an execute step in which the
// checks run and the entry RAM (registered read at the head slot) is written or read.
// A new item may be taken while the previous result still waits on m_*; the execute
// step holds while the result register is occupied and m_ready is low.
// Reset (aresetn low at a clock edge) empties the FIFO and forgets the last sequence;
// RAM contents are left as they are and are never read before being written.
`include "sequenced_input_fifo_core_macros.svh"

module sequenced_input_fifo_core
    import sif_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [SEQ_W-1:0]      s_in_sequence,
    input  logic [PORT_PAY_W-1:0] s_in_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [SEQ_W-1:0]      m_out_sequence,
    output logic [PORT_PAY_W-1:0] m_out_payload
);

    cmd_t     cmd;
    dp_stat_t stat;

    // sequencer: decides when to capture an item and when to commit its result
    sif_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // checks, pointers, entry storage and result registers
    sif_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_mode         (s_mode),
        .s_in_sequence  (s_in_sequence),
        .s_in_payload   (s_in_payload),
        .m_status       (m_status),
        .m_out_sequence (m_out_sequence),
        .m_out_payload  (m_out_payload)
    );

    // fill level never passes the ring size
    `SIF_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(DEPTH))
    // a captured item blocks the input until its result is committed
    `SIF_ASSERT_NEXT(a_busy_after_capture, s_valid && s_ready, !s_ready)
    // only a pop that found an entry shows nonzero data
    `SIF_ASSERT_NOW(a_zero_unless_popped, m_valid && (m_status != ST_POPPED),
        (m_out_sequence == '0) && (m_out_payload == '0))

endmodule

/* sim/sequenced_input_fifo_core_tb.sv */
// Testbench for sequenced_input_fifo_core: push/pop traffic with random backpressure,
// checked against a behavioral copy of the sequence-checked ring buffer.
// Depends on sif_pkg and the RTL of sequenced_input_fifo_core.
module sequenced_input_fifo_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sif_pkg::*;

    localparam int CLOCK_LIMIT    = 200_000;   // cycles before the run is declared hung
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_IDLE       = 12;
    localparam int HOLD_CYCLES    = 300;       // long receiver hold-off, fills the pipeline
    localparam int TAIL_CYCLES    = 16;        // settle time after the last expected result
    localparam int PHASES         = 12;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int REPORT_LIMIT   = 10;

    // One result of the block: status plus the popped entry, zero unless popped.
    typedef struct {
        status_t                status;
        logic [SEQ_W-1:0]       seq;
        logic [PORT_PAY_W-1:0]  pay;
    } response_t;

    // Mirrors the ring buffer and the last accepted sequence; keeps the responses still
    // owed by the block, oldest first.
    class seq_fifo_tracker;
        logic [SEQ_W-1:0]       seq_ring [DEPTH];
        logic [PORT_PAY_W-1:0]  pay_ring [DEPTH];
        int                     head;
        int                     fill;
        logic [SEQ_W-1:0]       last_seq;
        bit                     have_seq;
        response_t              awaited [$];
        int                     mismatches;

        function new();
            head       = 0;
            fill       = 0;
            last_seq   = '0;
            have_seq   = 1'b0;
            mismatches = 0;
        endfunction

        // Next in-order sequence; zero is never a valid sequence, so the wrap lands on one.
        function logic [SEQ_W-1:0] next_seq();
            logic [SEQ_W-1:0] n;
            n = last_seq + 1'b1;
            if (n == '0) n = SEQ_W'(1);
            return n;
        endfunction

        // Serial-number order: newer when the forward distance is 1 .. 2^31-1.
        function bit newer_than_last(logic [SEQ_W-1:0] s);
            logic [SEQ_W-1:0] fwd_gap;
            fwd_gap = s - last_seq;
            return (fwd_gap != '0) && (fwd_gap < 32'h8000_0000);
        endfunction

        function logic [PORT_PAY_W-1:0] payload_mask();
            if (PAYLOAD_BITS >= PORT_PAY_W) return '1;
            return (64'd1 << PAYLOAD_BITS) - 1;
        endfunction

        function void note_command(mode_t mode, logic [SEQ_W-1:0] seq,
                                   logic [PORT_PAY_W-1:0] pay);
            response_t r;
            int        slot;
            r.status = ST_ACCEPTED;
            r.seq    = '0;
            r.pay    = '0;
            if (mode == MODE_PUSH) begin
                if (seq == '0) begin
                    r.status = ST_STALE;
                end else if (have_seq && !newer_than_last(seq)) begin
                    r.status = ST_STALE;
                end else if (have_seq && seq != next_seq()) begin
                    r.status = ST_GAP;
                end else if (fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    slot           = (head + fill) % DEPTH;
                    seq_ring[slot] = seq;
                    pay_ring[slot] = pay & payload_mask();
                    fill++;
                    last_seq       = seq;
                    have_seq       = 1'b1;
                end
            end else if (fill == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_POPPED;
                r.seq    = seq_ring[head];
                r.pay    = pay_ring[head];
                head     = (head + 1) % DEPTH;
                fill--;
            end
            awaited.push_back(r);
        endfunction

        function void check_response(logic [2:0] status, logic [SEQ_W-1:0] seq,
                                     logic [PORT_PAY_W-1:0] pay);
            response_t e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result: status %0d sequence %h payload %h",
                             $realtime, status, seq, pay);
                return;
            end
            e = awaited.pop_front();
            if (status !== e.status || seq !== e.seq || pay !== e.pay) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $write("%0t: mismatch: status exp %0d got %0d, sequence exp %h got %h,",
                           $realtime, e.status, status, e.seq, seq);
                    $display(" payload exp %h got %h", e.pay, pay);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic [SEQ_W-1:0]      s_in_sequence;
    logic [PORT_PAY_W-1:0] s_in_payload;
    logic                  m_valid;
    logic                  m_ready;
    logic [2:0]            m_status;
    logic [SEQ_W-1:0]      m_out_sequence;
    logic [PORT_PAY_W-1:0] m_out_payload;

    seq_fifo_tracker tracker = new();

    // Set by the sender; the receiver reads the hold and receive flags, the watchdog counts.
    bit  hold_request  = 1'b0;   // sender asks the receiver for one long hold-off
    bit  send_no_idle  = 1'b0;   // current phase sends back to back
    bit  recv_no_idle  = 1'b0;   // current phase takes results back to back
    int  cycle_count   = 0;

    sequenced_input_fifo_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_in_sequence  (s_in_sequence),
        .s_in_payload   (s_in_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_sequence (m_out_sequence),
        .m_out_payload  (m_out_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: end a hung run.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CLOCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int draw_idle(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Offer one command. Call at a falling edge; return at the falling edge after the
    // transfer. Valid drops only when a gap is drawn, so a back-to-back item never sees
    // valid lowered and raised in the same time step.
    task automatic send_command(input mode_t mode, input logic [SEQ_W-1:0] seq,
                                input logic [PORT_PAY_W-1:0] pay, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_in_sequence <= seq;
        s_in_payload  <= pay;
        do @(posedge aclk); while (!s_ready);
        tracker.note_command(mode, seq, pay);
        @(negedge aclk);
    endtask

    task automatic send_idle_spaced(input mode_t mode, input logic [SEQ_W-1:0] seq,
                                    input logic [PORT_PAY_W-1:0] pay);
        send_command(mode, seq, pay, draw_idle(send_no_idle));
    endtask

    // Draw one random command. Most pushes carry the next in-order sequence so the
    // buffer actually fills and drains; the rest probe stale, gap and boundary cases.
    function automatic void pick_command(input int push_pct, output mode_t mode,
                                         output logic [SEQ_W-1:0] seq,
                                         output logic [PORT_PAY_W-1:0] pay);
        int kind;
        mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
        seq  = $urandom;
        pay  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind == 0) pay = '0;
        if (kind == 1) pay = '1;
        if (mode == MODE_PUSH) begin
            kind = $urandom_range(0, 19);
            if (kind < 15)
                seq = tracker.next_seq();
            else if (kind == 15)
                seq = '0;
            else if (kind == 16)
                seq = tracker.last_seq - $urandom_range(0, 5);
            else if (kind == 17)
                seq = tracker.last_seq + $urandom_range(2, 9);
            else if (kind == 18)
                seq = tracker.last_seq + 32'h8000_0000 - $urandom_range(0, 1);
        end
    endfunction

    // Receiver: random stall before each result, one long hold-off on request.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                // hold ready low long enough for the block to back up into s_ready
                m_ready     <= 1'b0;
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = draw_idle(recv_no_idle);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            tracker.check_response(m_status, m_out_sequence, m_out_payload);
        end
    end

    // Sender: reset, directed cases, then phases of random traffic.
    initial begin
        mode_t                 mode;
        logic [SEQ_W-1:0]      seq;
        logic [PORT_PAY_W-1:0] pay;
        int                    push_pct;
        int                    weights [5];

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_mode        = MODE_PUSH;
        s_in_sequence = '0;
        s_in_payload  = '0;
        weights       = '{20, 50, 50, 70, 90};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. Pop with nothing stored; fields of a pop are don't-care.
        send_idle_spaced(MODE_POP, '1, '1);
        // Zero sequence is stale even before any history.
        send_idle_spaced(MODE_PUSH, '0, 64'h0123_4567_89ab_cdef);
        // First push sets the history from any nonzero value; start near the wrap.
        send_idle_spaced(MODE_PUSH, 32'hFFFF_FFFE, '1);
        // Same sequence again and an older one: both stale.
        send_idle_spaced(MODE_PUSH, 32'hFFFF_FFFE, '0);
        send_idle_spaced(MODE_PUSH, 32'hFFFF_FFF0, 64'h5555_5555_5555_5555);
        send_idle_spaced(MODE_PUSH, 32'hFFFF_FFFF, '0);
        // Zero after history: stale, not the successor of all-ones.
        send_idle_spaced(MODE_PUSH, '0, 64'hAAAA_AAAA_AAAA_AAAA);
        // Newer but skipping one: gap. Then the real successor skips zero.
        send_idle_spaced(MODE_PUSH, 32'd2, 64'hdead_beef_0000_0001);
        send_idle_spaced(MODE_PUSH, 32'd1, 64'h8000_0000_0000_0001);
        // Half-range distance is not newer; one less is newer but a gap.
        send_idle_spaced(MODE_PUSH, 32'h8000_0001, '1);
        send_idle_spaced(MODE_PUSH, 32'h8000_0000, '1);
        // Drain the three stored entries in order, then one more pop finds it empty.
        send_idle_spaced(MODE_POP, '0, '0);
        send_idle_spaced(MODE_POP, '1, '0);
        send_idle_spaced(MODE_POP, 32'h1234_5678, '1);
        send_idle_spaced(MODE_POP, '0, '1);

        // Random part. The first phase leans hard on pushes so the buffer overflows.
        for (int phase = 0; phase < PHASES; phase++) begin
            push_pct     = (phase == 0) ? 90 : weights[$urandom_range(0, 4)];
            send_no_idle = ($urandom_range(0, 3) == 0);
            recv_no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                // long receiver hold-off while pushes keep coming back to back
                push_pct     = 90;
                send_no_idle = 1'b1;
                hold_request = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 7 && i == ITEMS_PER_PHASE / 2) begin
                    // pause until the block has delivered everything owed
                    s_valid <= 1'b0;
                    while (tracker.awaited.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                pick_command(push_pct, mode, seq, pay);
                send_idle_spaced(mode, seq, pay);
            end
        end
        s_valid <= 1'b0;

        // Wait for every owed result, then a settling tail to catch strays.
        while (tracker.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sequenced_input_fifo_core.f */
+incdir+hdl
hdl/sif_pkg.sv
hdl/sif_ram.sv
hdl/sif_datapath.sv
hdl/sif_ctrl.sv
hdl/sequenced_input_fifo_core.sv
sim/sequenced_input_fifo_core_tb.sv
